@@ sv/fmrwd_pkg.sv @@
// Package with the shared types, constants and init table of the FM register write doubler.
`default_nettype none
package fmrwd_pkg;

    localparam int unsigned SHADOW_DEPTH = 512;
    localparam int unsigned SHADOW_AW    = 9;
    localparam int unsigned NUM_CHANNELS = 9;
    localparam int unsigned INIT_LEN     = 57;
    localparam int unsigned INIT_IW      = 6;
    localparam int unsigned STEP_NUM     = 7;
    localparam int unsigned STEP_W       = 3;

    localparam logic [0:0] OP_WRITE  = 1'b0;
    localparam logic [0:0] OP_INIT   = 1'b1;
    localparam logic [0:0] KIND_WRITE = 1'b0;
    localparam logic [0:0] KIND_WAIT  = 1'b1;

    localparam logic [2:0] CFG_STEREO_INIT = 3'd0;
    localparam logic [2:0] CFG_PAN_SPLIT   = 3'd1;
    localparam logic [2:0] CFG_DETUNE      = 3'd2;
    localparam logic [2:0] CFG_ATTEN0      = 3'd3;
    localparam logic [2:0] CFG_ATTEN1      = 3'd4;
    localparam logic [2:0] CFG_KEYON_WAIT  = 3'd5;

    localparam logic [7:0] REG_RHYTHM = 8'hBD;
    localparam logic [7:0] PAN_LEFT   = 8'hA0;
    localparam logic [7:0] PAN_RIGHT  = 8'h50;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RUN,
        ST_INIT
    } state_t;

    typedef enum logic [2:0] {
        CL_FLO,
        CL_FHI,
        CL_CTL,
        CL_TL,
        CL_RHY,
        CL_OTHER
    } class_t;

    typedef struct packed {
        logic [0:0] kind;
        logic [0:0] bank;
        logic [7:0] rgi;
        logic [7:0] val;
    } emit_t;

    localparam logic [7:0] EXT_WAVE [14] = '{
        8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE8,
        8'hE9, 8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF
    };

    function automatic emit_t init_entry(input logic [INIT_IW-1:0] idx, input logic stereo);
        emit_t      e;
        logic [5:0] k;
        e.kind = KIND_WRITE;
        e.bank = 1'b0;
        e.rgi  = 8'h00;
        e.val  = 8'h00;
        k      = 6'd0;
        if (idx == 6'd0) begin
            e.bank = 1'b1; e.rgi = 8'h05; e.val = 8'h01;
        end else if (idx == 6'd1) begin
            e.bank = 1'b1; e.rgi = 8'h04;
        end else if (idx == 6'd2) begin
            e.rgi = 8'h01;
        end else if (idx == 6'd3) begin
            e.rgi = 8'h08;
        end else if (idx == 6'd4) begin
            e.bank = 1'b1; e.rgi = 8'h01;
        end else if (idx < 6'd23) begin
            k      = idx - 6'd5;
            e.bank = k[0];
            e.rgi  = 8'hC0 + {4'd0, k[4:1]};
            if (stereo && k[1]) begin
                e.val = k[0] ? PAN_LEFT : PAN_RIGHT;
            end else begin
                e.val = k[0] ? PAN_LEFT : PAN_RIGHT;
                if (stereo) begin
                    e.val = k[0] ? PAN_RIGHT : PAN_LEFT;
                end
            end
        end else if (idx < 6'd51) begin
            k      = idx - 6'd23;
            e.bank = k[0];
            e.rgi  = EXT_WAVE[k[4:1]];
        end else begin
            k      = idx - 6'd51;
            e.bank = 1'b1;
            e.rgi  = 8'hF0 + {5'd0, k[2:0]};
        end
        return e;
    endfunction

endpackage
`default_nettype wire

@@ sv/fmrwd_if.sv @@
// Handshake interfaces for the input and result channels of the doubler.
`default_nettype none
interface fmrwd_in_if;
    logic       valid;
    logic       ready;
    logic [0:0] operation;
    logic [7:0] reg_index;
    logic [7:0] value;
    modport source (output valid, operation, reg_index, value, input ready);
    modport sink (input valid, operation, reg_index, value, output ready);
endinterface

interface fmrwd_out_if;
    logic        valid;
    logic        ready;
    logic [0:0]  kind;
    logic [0:0]  bank;
    logic [7:0]  out_reg;
    logic [7:0]  out_value;
    logic [15:0] wait_samples;
    logic        last;
    modport source (output valid, kind, bank, out_reg, out_value, wait_samples, last,
                    input ready);
    modport sink (input valid, kind, bank, out_reg, out_value, wait_samples, last,
                  output ready);
endinterface
`default_nettype wire

@@ sv/fm_register_write_doubler.sv @@
// Top level of the FM register write doubler with its shadow memory and write sequencer.
// Flow: an input transaction first reads the shadow memory, then emits one result per
// cycle while the output is not stalled (up to 7 for a register write); the next input
// is taken in the cycle of the previous item's last result, or once the shadow read is
// done when a register write emits nothing.
// Init clears all 512 shadow entries and then emits 57 results.
// After reset the same clearing pass runs before the first input is taken.
`default_nettype none
module fm_register_write_doubler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    fmrwd_in_if.sink         in_ch,
    fmrwd_out_if.source      out_ch
);

    logic        stereo_reg;
    logic        pan_split_reg;
    logic [17:0] detune_reg;
    logic [5:0]  atten0_reg;
    logic [5:0]  atten1_reg;
    logic [15:0] keyon_wait_reg;

    fmrwd_pkg::state_t state_reg, state_next;
    fmrwd_pkg::class_t cls_reg, cls_next;
    logic [fmrwd_pkg::SHADOW_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic                            init_pend_reg, init_pend_next;
    logic [fmrwd_pkg::INIT_IW-1:0]   idx_reg, idx_next;
    logic [fmrwd_pkg::STEP_NUM-1:0]  mask_reg, mask_next;
    logic [fmrwd_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                            rhythm_reg, rhythm_next;
    logic                            out_valid_reg, out_valid_next;

    logic [7:0]  rgi_reg;
    logic [7:0]  val_reg;
    logic [7:0]  a_reg;
    logic        rhy_reg;
    logic        fwd_hit_reg;
    logic [7:0]  fwd_data_reg;
    logic signed [28:0] prod_reg;
    logic [9:0]  fdet_reg;

    fmrwd_pkg::emit_t out_item_reg;
    logic [15:0] out_wait_reg;
    logic        out_last_reg;

    logic [7:0] shadow_mem [fmrwd_pkg::SHADOW_DEPTH];
    logic [7:0] rdata_reg;

    logic                            mem_we;
    logic [fmrwd_pkg::SHADOW_AW-1:0] mem_waddr;
    logic [7:0]                      mem_wdata;
    logic [fmrwd_pkg::SHADOW_AW-1:0] mem_raddr;

    logic        cfg_wr;
    logic        emit_go;
    logic        run_empty;
    logic        run_emit;
    logic        init_emit;
    logic        step_last;
    logic        finishing;
    logic        accept;
    logic [7:0]  a_rd;
    logic [7:0]  ra;
    logic [9:0]  fnum;
    logic signed [29:0] tsum;
    logic [7:0]  oa;
    logic [7:0]  ob;
    logic [7:0]  pan0;
    logic [7:0]  pan1;
    logic        rhy_now;
    fmrwd_pkg::emit_t step_item;
    fmrwd_pkg::emit_t init_item;
    fmrwd_pkg::emit_t load_item;
    logic        load_last;

    function automatic logic [7:0] tl_atten(input logic [7:0] v, input logic [5:0] att);
        logic [6:0] s;
        s = {1'b0, v[5:0]} + {1'b0, att};
        return {v[7:6], (s > 7'd63) ? 6'd63 : s[5:0]};
    endfunction

    function automatic logic [fmrwd_pkg::STEP_W-1:0] first_from(
        input logic [fmrwd_pkg::STEP_NUM-1:0] m, input logic [fmrwd_pkg::STEP_W:0] from);
        logic [fmrwd_pkg::STEP_W-1:0] r;
        logic                         found;
        r     = '0;
        found = 1'b0;
        for (int i = 0; i < fmrwd_pkg::STEP_NUM; i++) begin
            if (!found && m[i] && (i >= int'(from))) begin
                r     = fmrwd_pkg::STEP_W'(i);
                found = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic any_from(
        input logic [fmrwd_pkg::STEP_NUM-1:0] m, input logic [fmrwd_pkg::STEP_W:0] from);
        logic f;
        f = 1'b0;
        for (int i = 0; i < fmrwd_pkg::STEP_NUM; i++) begin
            if (m[i] && (i >= int'(from))) begin
                f = 1'b1;
            end
        end
        return f;
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stereo_reg     <= 1'b0;
            pan_split_reg  <= 1'b0;
            detune_reg     <= '0;
            atten0_reg     <= '0;
            atten1_reg     <= '0;
            keyon_wait_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                fmrwd_pkg::CFG_STEREO_INIT: stereo_reg     <= pwdata[0];
                fmrwd_pkg::CFG_PAN_SPLIT:   pan_split_reg  <= pwdata[0];
                fmrwd_pkg::CFG_DETUNE:      detune_reg     <= pwdata[17:0];
                fmrwd_pkg::CFG_ATTEN0:      atten0_reg     <= pwdata[5:0];
                fmrwd_pkg::CFG_ATTEN1:      atten1_reg     <= pwdata[5:0];
                fmrwd_pkg::CFG_KEYON_WAIT:  keyon_wait_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            fmrwd_pkg::CFG_STEREO_INIT: prdata = {31'd0, stereo_reg};
            fmrwd_pkg::CFG_PAN_SPLIT:   prdata = {31'd0, pan_split_reg};
            fmrwd_pkg::CFG_DETUNE:      prdata = {{14{detune_reg[17]}}, detune_reg};
            fmrwd_pkg::CFG_ATTEN0:      prdata = {26'd0, atten0_reg};
            fmrwd_pkg::CFG_ATTEN1:      prdata = {26'd0, atten1_reg};
            fmrwd_pkg::CFG_KEYON_WAIT:  prdata = {16'd0, keyon_wait_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // The frequency pair of a channel sits 0x10 apart, so the partner address is a bit flip.
    assign ra        = rgi_reg ^ 8'h10;
    assign mem_raddr = {1'b0, in_ch.reg_index ^ 8'h10};
    assign a_rd      = fwd_hit_reg ? fwd_data_reg : rdata_reg;
    assign rhy_now   = (rgi_reg[3:0] >= 4'd6) && rhythm_reg;

    assign fnum = {val_reg[1:0], a_reg};
    assign tsum = 30'(signed'({4'd0, fnum, 16'd0})) + 30'(prod_reg) + 30'sd32768;

    always_ff @(posedge clk) begin
        prod_reg <= signed'({1'b0, fnum}) * signed'(detune_reg);
        if (tsum < 0) begin
            fdet_reg <= 10'd0;
        end else if (tsum[29:16] > 14'd1023) begin
            fdet_reg <= 10'd1023;
        end else begin
            fdet_reg <= tsum[25:16];
        end
    end

    assign oa = rhy_reg ? a_reg : fdet_reg[7:0];
    assign ob = {val_reg[7:2], fdet_reg[9:8]};

    always_comb begin
        pan0 = fmrwd_pkg::PAN_LEFT;
        pan1 = fmrwd_pkg::PAN_RIGHT;
        if (pan_split_reg && !rgi_reg[0]) begin
            pan0 = fmrwd_pkg::PAN_RIGHT;
            pan1 = fmrwd_pkg::PAN_LEFT;
        end
    end

    always_comb begin
        step_item.kind = fmrwd_pkg::KIND_WRITE;
        step_item.bank = step_reg[0] ? 1'b1 : 1'b0;
        step_item.rgi  = rgi_reg;
        step_item.val  = val_reg;
        case (cls_reg)
            fmrwd_pkg::CL_FHI: begin
                case (step_reg)
                    3'd1: begin
                        step_item.bank = 1'b0;
                        step_item.rgi  = ra;
                        step_item.val  = a_reg;
                    end
                    3'd3, 3'd6: begin
                        step_item.kind = fmrwd_pkg::KIND_WAIT;
                        step_item.bank = 1'b0;
                        step_item.rgi  = 8'd0;
                        step_item.val  = 8'd0;
                    end
                    3'd4: begin
                        step_item.bank = 1'b1;
                        step_item.rgi  = ra;
                        step_item.val  = oa;
                    end
                    3'd5: begin
                        step_item.bank = 1'b1;
                        step_item.val  = ob;
                    end
                    default: step_item.bank = 1'b0;
                endcase
            end
            fmrwd_pkg::CL_CTL: step_item.val = val_reg | (step_reg[0] ? pan1 : pan0);
            fmrwd_pkg::CL_TL:
                step_item.val = tl_atten(val_reg, step_reg[0] ? atten1_reg : atten0_reg);
            default: ;
        endcase
    end

    assign init_item = fmrwd_pkg::init_entry(idx_reg, stereo_reg);

    assign emit_go   = !out_valid_reg || out_ch.ready;
    assign step_last = !any_from(mask_reg, {1'b0, step_reg} + 4'd1);
    assign run_empty = (state_reg == fmrwd_pkg::ST_RUN) && (mask_reg == '0);
    assign run_emit  = (state_reg == fmrwd_pkg::ST_RUN) && (mask_reg != '0) && emit_go;
    assign init_emit = (state_reg == fmrwd_pkg::ST_INIT) && emit_go;
    assign finishing = run_empty || (run_emit && step_last)
                    || (init_emit && (idx_reg == fmrwd_pkg::INIT_IW'(fmrwd_pkg::INIT_LEN - 1)));
    assign in_ch.ready = (state_reg == fmrwd_pkg::ST_IDLE) || finishing;
    assign accept      = in_ch.valid && in_ch.ready;

    assign load_item = run_emit ? step_item : init_item;
    assign load_last = run_emit ? step_last
                     : (idx_reg == fmrwd_pkg::INIT_IW'(fmrwd_pkg::INIT_LEN - 1));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {1'b0, rgi_reg};
        mem_wdata = val_reg;
        if (state_reg == fmrwd_pkg::ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 8'd0;
        end else if (run_empty) begin
            mem_we = 1'b1;
        end else if ((run_emit || init_emit) && (load_item.kind == fmrwd_pkg::KIND_WRITE)) begin
            mem_we    = 1'b1;
            mem_waddr = {load_item.bank, load_item.rgi};
            mem_wdata = load_item.val;
        end
    end

    always_ff @(posedge clk) begin
        if (mem_we) begin
            shadow_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= shadow_mem[mem_raddr];
    end

    always_comb begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        clr_cnt_next   = clr_cnt_reg;
        init_pend_next = init_pend_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        step_next      = step_reg;
        rhythm_next    = rhythm_reg;
        out_valid_next = out_valid_reg;

        if (out_ch.ready) begin
            out_valid_next = 1'b0;
        end
        if (run_emit || init_emit) begin
            out_valid_next = 1'b1;
        end
        if (mem_we && (mem_waddr[7:0] == fmrwd_pkg::REG_RHYTHM)
            && (state_reg != fmrwd_pkg::ST_CLEAR)) begin
            rhythm_next = mem_wdata[5];
        end

        unique case (state_reg)
            fmrwd_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == fmrwd_pkg::SHADOW_AW'(fmrwd_pkg::SHADOW_DEPTH - 1)) begin
                    idx_next   = '0;
                    state_next = init_pend_reg ? fmrwd_pkg::ST_INIT : fmrwd_pkg::ST_IDLE;
                end
            end
            fmrwd_pkg::ST_READ: begin
                case (cls_reg)
                    fmrwd_pkg::CL_FLO: mask_next = {6'd0, a_rd[5]};
                    fmrwd_pkg::CL_FHI:
                        mask_next = {keyon_wait_reg != 16'd0, !rhy_now, 1'b1,
                                     keyon_wait_reg != 16'd0, 3'b111};
                    fmrwd_pkg::CL_RHY: mask_next = 7'b0000001;
                    default:           mask_next = 7'b0000011;
                endcase
                step_next  = '0;
                state_next = fmrwd_pkg::ST_RUN;
            end
            fmrwd_pkg::ST_RUN: begin
                if (run_emit && !step_last) begin
                    step_next = first_from(mask_reg, {1'b0, step_reg} + 4'd1);
                end
            end
            fmrwd_pkg::ST_INIT: begin
                if (init_emit) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: ;
        endcase

        if (finishing) begin
            state_next = fmrwd_pkg::ST_IDLE;
        end
        if (accept) begin
            if (in_ch.operation == fmrwd_pkg::OP_INIT) begin
                state_next     = fmrwd_pkg::ST_CLEAR;
                clr_cnt_next   = '0;
                init_pend_next = 1'b1;
                rhythm_next    = 1'b0;
            end else begin
                state_next = fmrwd_pkg::ST_READ;
                if (in_ch.reg_index >= 8'hA0 && in_ch.reg_index <= 8'hA8) begin
                    cls_next = fmrwd_pkg::CL_FLO;
                end else if (in_ch.reg_index >= 8'hB0 && in_ch.reg_index <= 8'hB8) begin
                    cls_next = fmrwd_pkg::CL_FHI;
                end else if (in_ch.reg_index >= 8'hC0 && in_ch.reg_index <= 8'hC8) begin
                    cls_next = fmrwd_pkg::CL_CTL;
                end else if (in_ch.reg_index >= 8'h40 && in_ch.reg_index <= 8'h55) begin
                    cls_next = fmrwd_pkg::CL_TL;
                end else if (in_ch.reg_index == fmrwd_pkg::REG_RHYTHM) begin
                    cls_next = fmrwd_pkg::CL_RHY;
                end else begin
                    cls_next = fmrwd_pkg::CL_OTHER;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= fmrwd_pkg::ST_CLEAR;
            cls_reg       <= fmrwd_pkg::CL_OTHER;
            clr_cnt_reg   <= '0;
            init_pend_reg <= 1'b0;
            idx_reg       <= '0;
            mask_reg      <= '0;
            step_reg      <= '0;
            rhythm_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cls_reg       <= cls_next;
            clr_cnt_reg   <= clr_cnt_next;
            init_pend_reg <= init_pend_next;
            idx_reg       <= idx_next;
            mask_reg      <= mask_next;
            step_reg      <= step_next;
            rhythm_reg    <= rhythm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            rgi_reg      <= in_ch.reg_index;
            val_reg      <= in_ch.value;
            fwd_hit_reg  <= mem_we && (mem_waddr == mem_raddr);
            fwd_data_reg <= mem_wdata;
        end
        if (state_reg == fmrwd_pkg::ST_READ) begin
            a_reg   <= a_rd;
            rhy_reg <= rhy_now;
        end
        if (run_emit || init_emit) begin
            out_item_reg <= load_item;
            out_last_reg <= load_last;
            out_wait_reg <= (load_item.kind == fmrwd_pkg::KIND_WAIT) ? keyon_wait_reg : 16'd0;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_item_reg.kind;
    assign out_ch.bank         = out_item_reg.bank;
    assign out_ch.out_reg      = out_item_reg.rgi;
    assign out_ch.out_value    = out_item_reg.val;
    assign out_ch.wait_samples = out_wait_reg;
    assign out_ch.last         = out_last_reg;

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fmrwd_pkg::ST_CLEAR) |-> !in_ch.ready)
        else $error("input taken during the shadow clearing pass");

    a_no_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fmrwd_pkg::ST_READ) |-> !in_ch.ready)
        else $error("input taken while a shadow read is in flight");

    a_read_to_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fmrwd_pkg::ST_READ) |=> (state_reg == fmrwd_pkg::ST_RUN))
        else $error("shadow read not followed by the write sequence");

    a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.kind == fmrwd_pkg::KIND_WAIT) |-> (out_wait_reg != 16'd0))
        else $error("wait marker with a zero sample count");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the FM register write doubler: directed table plus random writes and inits.
`default_nettype none
module tb;
    import fmrwd_pkg::*;

    typedef struct packed {
        logic [0:0]  kind;
        logic [0:0]  bank;
        logic [7:0]  rgi;
        logic [7:0]  val;
        logic [15:0] wait_samples;
        logic        last;
    } wr_result_t;

    typedef struct {
        logic [0:0] op;
        logic [7:0] rgi;
        logic [7:0] val;
        bit         typed;
        wr_result_t first_res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fmrwd_in_if  in_ch();
    fmrwd_out_if out_ch();

    fm_register_write_doubler dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #5 clk = ~clk;

    logic [7:0]       shadow [SHADOW_DEPTH];
    logic             rhythm_flag;
    logic             m_stereo, m_split;
    logic signed [17:0] m_detune;
    logic [5:0]       m_att0, m_att1;
    logic [15:0]      m_wait;

    wr_result_t       pending_writes[$];
    int               mismatches = 0;
    int               cycles = 0;
    int               send_idle = 0;
    int               recv_idle = 0;
    bit               hold_off = 1'b0;

    task automatic push_write(input logic b, input logic [7:0] r, input logic [7:0] v);
        wr_result_t e;
        shadow[{b, r}] = v;
        if (r == REG_RHYTHM) rhythm_flag = v[5];
        e = '{KIND_WRITE, b, r, v, 16'd0, 1'b0};
        pending_writes.push_back(e);
    endtask

    task automatic push_wait();
        wr_result_t e;
        if (m_wait != 0)
        begin
            e = '{KIND_WAIT, 1'b0, 8'd0, 8'd0, m_wait, 1'b0};
            pending_writes.push_back(e);
        end
    endtask

    function automatic logic [9:0] detune_fnum(input logic [9:0] f);
        longint t;
        t = longint'(f) * 65536 + longint'(f) * longint'(m_detune) + 32768;
        if (t < 0) return 10'd0;
        t = t >>> 16;
        return (t > 1023) ? 10'd1023 : t[9:0];
    endfunction

    function automatic logic [7:0] add_atten(input logic [7:0] v, input logic [5:0] a);
        int tl;
        tl = v[5:0] + a;
        if (tl > 63) tl = 63;
        return {v[7:6], 6'(tl)};
    endfunction

    task automatic predict_item(input logic [0:0] op, input logic [7:0] r,
                                input logic [7:0] v);
        int          n0;
        int          ch;
        logic [7:0]  ra, a, b, p0, p1;
        logic [9:0]  f;
        bit          rhy;
        n0 = pending_writes.size();
        if (op == OP_INIT)
        begin
            foreach (shadow[i]) shadow[i] = 8'd0;
            rhythm_flag = 1'b0;
            push_write(1, 8'h05, 8'h01);
            push_write(1, 8'h04, 8'h00);
            push_write(0, 8'h01, 8'h00);
            push_write(0, 8'h08, 8'h00);
            push_write(1, 8'h01, 8'h00);
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (m_stereo)
                begin
                    push_write(0, 8'(8'hC0 + i), i[0] ? PAN_RIGHT : PAN_LEFT);
                    push_write(1, 8'(8'hC0 + i), i[0] ? PAN_LEFT : PAN_RIGHT);
                end
                else
                begin
                    push_write(0, 8'(8'hC0 + i), PAN_RIGHT);
                    push_write(1, 8'(8'hC0 + i), PAN_LEFT);
                end
            end
            for (int i = 0; i < 14; i++)
            begin
                push_write(0, EXT_WAVE[i], 8'h00);
                push_write(1, EXT_WAVE[i], 8'h00);
            end
            for (int i = 0; i < 6; i++) push_write(1, 8'(8'hF0 + i), 8'h00);
        end
        else if (r >= 8'hA0 && r <= 8'hA8)
        begin
            shadow[{1'b0, r}] = v;
            if (shadow[{1'b0, r + 8'h10}][5]) push_write(0, r, v);
        end
        else if (r >= 8'hB0 && r <= 8'hB8)
        begin
            ch = r - 8'hB0;
            ra = 8'(8'hA0 + ch);
            push_write(0, r, v);
            push_write(0, ra, shadow[{1'b0, ra}]);
            push_write(0, r, v);
            push_wait();
            rhy = (ch >= 6) && rhythm_flag;
            a = shadow[{1'b0, ra}];
            b = shadow[{1'b0, r}];
            if (rhy)
                push_write(1, ra, a);
            else
            begin
                f = detune_fnum({b[1:0], a});
                push_write(1, ra, f[7:0]);
                push_write(1, r, {b[7:2], f[9:8]});
            end
            push_wait();
        end
        else if (r >= 8'hC0 && r <= 8'hC8)
        begin
            p0 = PAN_LEFT;
            p1 = PAN_RIGHT;
            if (m_split && !r[0]) begin p0 = PAN_RIGHT; p1 = PAN_LEFT; end
            push_write(0, r, v | p0);
            push_write(1, r, v | p1);
        end
        else if (r >= 8'h40 && r <= 8'h55)
        begin
            push_write(0, r, add_atten(v, m_att0));
            push_write(1, r, add_atten(v, m_att1));
        end
        else if (r == REG_RHYTHM)
            push_write(0, r, v);
        else
        begin
            push_write(0, r, v);
            push_write(1, r, v);
        end
        if (pending_writes.size() > n0)
            pending_writes[pending_writes.size() - 1].last = 1'b1;
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            CFG_STEREO_INIT: m_stereo = data[0];
            CFG_PAN_SPLIT:   m_split = data[0];
            CFG_DETUNE:      m_detune = data[17:0];
            CFG_ATTEN0:      m_att0 = data[5:0];
            CFG_ATTEN1:      m_att1 = data[5:0];
            CFG_KEYON_WAIT:  m_wait = data[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic s, input logic p, input int d,
                             input logic [5:0] a0, input logic [5:0] a1,
                             input logic [15:0] w);
        in_ch.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        reg_write(CFG_STEREO_INIT, 32'(s));
        reg_write(CFG_PAN_SPLIT, 32'(p));
        reg_write(CFG_DETUNE, 32'(d));
        reg_write(CFG_ATTEN0, 32'(a0));
        reg_write(CFG_ATTEN1, 32'(a1));
        reg_write(CFG_KEYON_WAIT, 32'(w));
    endtask

    task automatic send_item(input logic [0:0] op, input logic [7:0] r,
                             input logic [7:0] v);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.reg_index <= r;
        in_ch.value <= v;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict_item(op, r, v);
    endtask

    function automatic logic [7:0] pick_reg();
        case ($urandom_range(9))
            0, 1:    return 8'(8'hA0 + $urandom_range(8));
            2, 3:    return 8'(8'hB0 + $urandom_range(8));
            4:       return 8'(8'hC0 + $urandom_range(8));
            5:       return 8'(8'h40 + $urandom_range(21));
            6:       return REG_RHYTHM;
            default: return 8'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !hold_off && !($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        wr_result_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.kind, out_ch.bank, out_ch.out_reg, out_ch.out_value,
                    out_ch.wait_samples, out_ch.last};
            if (pending_writes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %p", got);
            end
            else
            begin
                want = pending_writes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", want, got);
                end
            end
        end
    end

    stim_row_t rows[$];

    initial
    begin
        stim_row_t rw;
        logic [0:0] op;
        logic [7:0] r;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_WRITE;
        in_ch.reg_index = '0;
        in_ch.value = '0;
        foreach (shadow[i]) shadow[i] = 8'd0;
        rhythm_flag = 0; m_stereo = 0; m_split = 0; m_detune = 0;
        m_att0 = 0; m_att1 = 0; m_wait = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        configure(1, 1, 65536, 63, 0, 16'hFFFF);
        // Init emits bank 1 register 5 first; other rows go through the predictor.
        rows = '{
            '{OP_INIT, 8'h00, 8'h00, 1, '{KIND_WRITE, 1'b1, 8'h05, 8'h01, 16'd0, 1'b0}},
            '{OP_WRITE, 8'hA0, 8'hFF, 0, '0}, '{OP_WRITE, 8'hB0, 8'h23, 0, '0},
            '{OP_WRITE, 8'hA0, 8'hFF, 0, '0}, '{OP_WRITE, 8'hB8, 8'hFF, 0, '0},
            '{OP_WRITE, 8'hBD, 8'h20, 0, '0}, '{OP_WRITE, 8'hB7, 8'h22, 0, '0},
            '{OP_WRITE, 8'hBD, 8'h00, 0, '0}, '{OP_WRITE, 8'hC0, 8'h0F, 0, '0},
            '{OP_WRITE, 8'hC1, 8'hFF, 0, '0}, '{OP_WRITE, 8'h40, 8'hFF, 0, '0},
            '{OP_WRITE, 8'h55, 8'h00, 0, '0}, '{OP_WRITE, 8'h00, 8'h00, 0, '0},
            '{OP_WRITE, 8'hFF, 8'hFF, 0, '0}, '{OP_WRITE, 8'hA8, 8'h55, 0, '0}
        };
        send_idle = 13; recv_idle = 81;
        foreach (rows[i])
        begin
            rw = rows[i];
            send_item(rw.op, rw.rgi, rw.val);
            if (rw.typed && pending_writes.size() > 0 &&
                pending_writes[0] != rw.first_res)
            begin
                mismatches++;
                $display("table row %0d expected %p", i, rw.first_res);
            end
        end
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: configure(0, 0, -65536, 0, 63, 0);
                1: configure(1, 0, 131071, 5, 40, 1);
                2: configure(0, 1, -131072, 31, 1, 16'h8000);
                3: configure(1, 1, $urandom_range(131071) - 65536, 6'($urandom),
                             6'($urandom), 16'($urandom));
                default: configure(0, 0, 0, 0, 0, 0);
            endcase
            if (ph == 2) begin send_idle = 81; recv_idle = 13; end
            if (ph >= 3) begin send_idle = 0; recv_idle = 0; end
            if (ph == 4)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            for (int k = 0; k < 70; k++)
            begin
                op = ($urandom_range(39) == 0) ? OP_INIT : OP_WRITE;
                r = pick_reg();
                send_item(op, r, 8'($urandom));
            end
        end
        in_ch.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
